FILE: rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder.
// Holds widths, codes, character constants, item types and hex/space decode.
// No dependencies.
package hcbd_pkg;

    localparam int SIZE_BITS  = 32;
    localparam int TICK_BITS  = 20;
    localparam int COUNT_BITS = 32;

    localparam logic [TICK_BITS-1:0] TIMEOUT_RESET = TICK_BITS'(15000);

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_BADLINE = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic                  out_valid;
        logic [7:0]            out_byte;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] body_count;
    } t_out_item;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

FILE: rtl/hcbd_core.sv
// Decoder state and next-state logic: line parser, body counter, tick timer.
// Depends on hcbd_pkg.
module hcbd_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  hcbd_pkg::t_in_item                i_item,
    input  logic                              i_cfg_we,
    input  logic [hcbd_pkg::TICK_BITS-1:0]    i_cfg_data,
    output hcbd_pkg::t_out_item               o_result
);

    localparam logic [3:0] PH_WS      = 4'd0;
    localparam logic [3:0] PH_SIGN    = 4'd1;
    localparam logic [3:0] PH_ZERO    = 4'd2;
    localparam logic [3:0] PH_X       = 4'd3;
    localparam logic [3:0] PH_DIGITS  = 4'd4;
    localparam logic [3:0] PH_EXT     = 4'd5;
    localparam logic [3:0] PH_BAD     = 4'd6;
    localparam logic [3:0] PH_BODY    = 4'd7;
    localparam logic [3:0] PH_DEND    = 4'd8;
    localparam logic [3:0] PH_TRAIL   = 4'd9;
    localparam logic [3:0] PH_TRAILCR = 4'd10;

    localparam int SB = hcbd_pkg::SIZE_BITS;
    localparam int CB = hcbd_pkg::COUNT_BITS;
    localparam int TB = hcbd_pkg::TICK_BITS;

    logic [TB-1:0] r_timeout;
    logic [3:0]    r_phase,  n_phase;
    logic [SB-1:0] r_chunk,  n_chunk;
    logic [TB-1:0] r_idle,   n_idle;
    logic          r_chars,  n_chars;
    logic [CB-1:0] r_total,  n_total;
    logic [1:0]    r_status, n_status;
    logic          body_out;
    logic [7:0]    c;
    hcbd_pkg::t_hex h;

    assign c = i_item.rx_byte;
    assign h = hcbd_pkg::hex_decode(c);

    always_comb begin
        n_phase  = r_phase;
        n_chunk  = r_chunk;
        n_idle   = r_idle;
        n_chars  = r_chars;
        n_total  = r_total;
        n_status = r_status;
        body_out = 1'b0;
        if (i_item.operation == hcbd_pkg::OP_START) begin
            n_phase  = PH_WS;
            n_chunk  = '0;
            n_idle   = '0;
            n_chars  = 1'b0;
            n_total  = '0;
            n_status = hcbd_pkg::ST_RUN;
        end else if (r_status == hcbd_pkg::ST_RUN) begin
            if (i_item.operation == hcbd_pkg::OP_BYTE) begin
                unique case (r_phase)
                    PH_WS, PH_SIGN: begin
                        if (c == hcbd_pkg::CH_LF) begin
                            n_status = hcbd_pkg::ST_BADLINE;
                        end else if (r_phase == PH_WS && hcbd_pkg::is_space(c)) begin
                            n_phase = r_phase;
                        end else if (r_phase == PH_WS && c == hcbd_pkg::CH_PLUS) begin
                            n_phase = PH_SIGN;
                        end else if (h.is_hex) begin
                            n_chunk = SB'(h.value);
                            n_phase = (h.value == 4'd0) ? PH_ZERO : PH_DIGITS;
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                    PH_ZERO, PH_X, PH_DIGITS, PH_EXT: begin
                        if (c == hcbd_pkg::CH_LF) begin
                            if (r_chunk == '0) begin
                                n_phase = PH_TRAIL;
                                n_idle  = '0;
                                n_chars = 1'b0;
                            end else begin
                                n_phase = PH_BODY;
                                n_idle  = '0;
                            end
                        end else if (r_phase == PH_EXT) begin
                            n_phase = PH_EXT;
                        end else if (r_phase == PH_ZERO &&
                                     (c == hcbd_pkg::CH_X_LO || c == hcbd_pkg::CH_X_UP)) begin
                            n_phase = PH_X;
                        end else if (h.is_hex) begin
                            n_chunk = (|r_chunk[SB-1 -: 4]) ? '1
                                    : {r_chunk[SB-5:0], h.value};
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_EXT;
                        end
                    end
                    PH_BAD: begin
                        if (c == hcbd_pkg::CH_LF) begin
                            n_status = hcbd_pkg::ST_BADLINE;
                        end
                    end
                    PH_BODY: begin
                        body_out = 1'b1;
                        n_total  = (r_total == '1) ? r_total : r_total + 1'b1;
                        n_idle   = '0;
                        n_chunk  = (r_chunk == '0) ? r_chunk : r_chunk - 1'b1;
                        if (n_chunk == '0) begin
                            n_phase = PH_DEND;
                            n_chars = 1'b0;
                        end
                    end
                    PH_DEND: begin
                        if (c == hcbd_pkg::CH_LF) begin
                            n_phase = PH_WS;
                            n_idle  = '0;
                            n_chars = 1'b0;
                        end
                    end
                    PH_TRAIL: begin
                        if (c == hcbd_pkg::CH_LF) begin
                            if (!r_chars) begin
                                n_status = hcbd_pkg::ST_DONE;
                            end else begin
                                n_idle  = '0;
                                n_chars = 1'b0;
                            end
                        end else if (c == hcbd_pkg::CH_CR && !r_chars) begin
                            n_phase = PH_TRAILCR;
                        end else begin
                            n_chars = 1'b1;
                        end
                    end
                    PH_TRAILCR: begin
                        if (c == hcbd_pkg::CH_LF) begin
                            n_status = hcbd_pkg::ST_DONE;
                        end else begin
                            n_chars = 1'b1;
                            n_phase = PH_TRAIL;
                        end
                    end
                    default: begin
                        n_status = hcbd_pkg::ST_BADLINE;
                    end
                endcase
            end else if (i_item.operation == hcbd_pkg::OP_TICK) begin
                if (r_idle >= r_timeout) begin
                    n_status = (r_phase == PH_TRAIL || r_phase == PH_TRAILCR)
                             ? hcbd_pkg::ST_DONE : hcbd_pkg::ST_TIMEOUT;
                end else begin
                    n_idle = r_idle + 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_result.out_valid  = body_out;
        o_result.out_byte   = body_out ? c : 8'd0;
        o_result.status     = n_status;
        o_result.body_count = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= hcbd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WS;
            r_chunk  <= '0;
            r_idle   <= '0;
            r_chars  <= 1'b0;
            r_total  <= '0;
            r_status <= hcbd_pkg::ST_RUN;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_chunk  <= n_chunk;
            r_idle   <= n_idle;
            r_chars  <= n_chars;
            r_total  <= n_total;
            r_status <= n_status;
        end
    end

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: input register, result register, handshakes.
// Depends on hcbd_pkg and hcbd_core.
//
// Takes one item (received byte, time tick or start of a new body) per clock when the output
// is not stalled and gives exactly one result for each, held in the result register after its
// transfer. An input register and a result register bracket the decoder state update,
// so a new item is taken every cycle while results are drained; the rate is set
// by that one decoder state update. The timeout register is written through the config
// channel, which is always ready; write it only while no item is in flight.
module http_chunked_body_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hcbd_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hcbd_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hcbd_pkg::TICK_BITS-1:0] i_cfg_data
);

    logic                r_in_vld;
    hcbd_pkg::t_in_item  r_in;
    logic                r_out_vld;
    hcbd_pkg::t_out_item r_out;
    hcbd_pkg::t_out_item result;
    logic                adv;

    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    hcbd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    a_body_while_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_valid) |-> (o_out_data.status == hcbd_pkg::ST_RUN))
        else $error("body byte reported with a final status");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |-> (o_out_data.out_byte == 8'd0))
        else $error("non-body result carries a byte");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("pipeline not empty after reset");

endmodule
